[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock with an active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset (i_clk, i_rst_n).
`define ASSERT_STD(lbl, prop, msg) \
    `ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

[design/svac_pkg.sv]
// Package: action, operator and operand codes, command and status types.
package svac_pkg;

    // Action codes
    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_SET   = 3'd1;
    localparam logic [2:0] ACT_IF    = 3'd2;
    localparam logic [2:0] ACT_UNTIL = 3'd3;
    localparam logic [2:0] ACT_ELSE  = 3'd4;
    localparam logic [2:0] ACT_IR    = 3'd5;

    // Operator codes (ASCII)
    localparam logic [6:0] OP_EQ  = 7'h3D; // '='
    localparam logic [6:0] OP_LT  = 7'h3C; // '<'
    localparam logic [6:0] OP_GT  = 7'h3E; // '>'
    localparam logic [6:0] OP_NE  = 7'h21; // '!'
    localparam logic [6:0] OP_GE  = 7'h47; // 'G'
    localparam logic [6:0] OP_LE  = 7'h4C; // 'L'
    localparam logic [6:0] OP_MUL = 7'h2A; // '*'
    localparam logic [6:0] OP_ADD = 7'h2B; // '+'
    localparam logic [6:0] OP_SUB = 7'h2D; // '-'
    localparam logic [6:0] OP_DIV = 7'h2F; // '/'

    // Operand codes
    localparam logic signed [7:0] CODE_LIT_MAX = 8'sd100;
    localparam logic signed [7:0] CODE_US      = 8'sd101;
    localparam logic signed [7:0] CODE_LINE    = 8'sd102;
    localparam logic signed [7:0] CODE_HIT     = 8'sd103;

    // Saturation limit of stored variables
    localparam logic signed [7:0] SAT_MAX = 8'sd100;
    localparam logic signed [7:0] SAT_MIN = -8'sd100;

    // Serial divider: one quotient bit per step
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load_item;  // capture the input item
        logic rd_b;       // variable read address: 0 operand A, 1 operand B
        logic cap_a;      // capture variable read data for operand A
        logic load_ops;   // decode both operands
        logic calc;       // compute result, compare and start divider
        logic div_step;   // one divider iteration
        logic commit;     // update state and load the result register
    } t_cmd;

    typedef struct packed {
        logic div_needed; // set action divides by a nonzero operand
    } t_sts;

endpackage

[design/svac_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module svac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/svac_ctrl.sv]
// Controller: sequences variable reads, operand decode, divider and commit.
module svac_ctrl import svac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RDA  = 3'd1;
    localparam logic [2:0] ST_RDB  = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_CALC = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_RDA;
                end
            end
            ST_RDA: begin
                n_state = ST_RDB;
            end
            ST_RDB: begin
                o_cmd.cap_a = 1'b1;
                o_cmd.rd_b  = 1'b1;
                n_state     = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.load_ops = 1'b1;
                n_state        = ST_CALC;
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_cnt      = '0;
                n_state    = i_sts.div_needed ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[design/svac_dp.sv]
// Datapath: variable file, operand decode, arithmetic, serial divider, result.
module svac_dp import svac_pkg::*; #(
    parameter int VARIABLE_COUNT      = 10,
    parameter int FIRST_VARIABLE_CODE = 104
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [2:0]         i_action,
    input  logic signed [7:0]  i_first_operand,
    input  logic [6:0]         i_operator_code,
    input  logic signed [7:0]  i_second_operand,
    input  logic signed [15:0] i_ultrasonic_reading,
    input  logic signed [15:0] i_line_reading,
    input  logic [15:0]        i_ir_event_value,
    output logic               o_truth,
    output logic signed [7:0]  o_written_value,
    output logic               o_divide_by_zero,
    output logic               o_bad_target
);

    localparam int IDX_W = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
    localparam logic signed [8:0] VAR_LO = 9'(FIRST_VARIABLE_CODE);
    localparam logic signed [8:0] VAR_HI = 9'(FIRST_VARIABLE_CODE + VARIABLE_COUNT);
    localparam logic signed [8:0] HIT_9  = 9'sd103;
    localparam logic [7:0]        FIRST_U = 8'(FIRST_VARIABLE_CODE);

    // Item registers
    logic [2:0]         r_action;
    logic signed [7:0]  r_code_a, r_code_b;
    logic [6:0]         r_op;
    logic signed [15:0] r_us, r_line;
    logic               r_irv_nz;

    // Work registers
    logic [7:0]         r_var_a;
    logic signed [15:0] r_opa, r_opb;
    logic signed [32:0] r_res;
    logic               r_truth, r_dz, r_div_sel;
    logic [15:0]        r_rem, r_quo, r_dvs;
    logic               r_qneg;

    // Block state
    logic                      r_hit, r_last_if;
    logic [VARIABLE_COUNT-1:0] r_vld;

    // Result register
    logic              r_o_truth, r_o_dz, r_o_bad;
    logic signed [7:0] r_o_written;

    logic [7:0]       ram_q;
    logic [IDX_W-1:0] idx_a, idx_b;
    logic [7:0]       diff_a, diff_b;
    logic             var_a_ok, var_b_ok, hit_b;
    logic signed [15:0] var_a_val, var_b_val, dec_a, dec_b;
    logic signed [31:0] prod;
    logic signed [16:0] sum, dif, div_val;
    logic [16:0]        trial;
    logic signed [32:0] full;
    logic signed [7:0]  sat;
    logic               is_set, tgt_ok, ram_we, cmp;

    function automatic logic is_var(input logic signed [7:0] code);
        logic signed [8:0] c;
        c = 9'(code);
        return (c > HIT_9) && (c >= VAR_LO) && (c < VAR_HI);
    endfunction

    function automatic logic signed [15:0] decode(
        input logic signed [7:0]  code,
        input logic signed [15:0] us,
        input logic signed [15:0] line,
        input logic               hit,
        input logic signed [15:0] var_val
    );
        logic signed [15:0] v;
        if (code <= CODE_LIT_MAX) begin
            v = 16'(code);
        end else if (code == CODE_US) begin
            v = us;
        end else if (code == CODE_LINE) begin
            v = line;
        end else if (code == CODE_HIT) begin
            v = {15'd0, hit};
        end else if (is_var(code)) begin
            v = var_val;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    function automatic logic [15:0] mag(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

    // Variable addressing
    assign diff_a = r_code_a - FIRST_U;
    assign diff_b = r_code_b - FIRST_U;
    assign idx_a  = diff_a[IDX_W-1:0];
    assign idx_b  = diff_b[IDX_W-1:0];
    assign var_a_ok = is_var(r_code_a) && r_vld[idx_a];
    assign var_b_ok = is_var(r_code_b) && r_vld[idx_b];
    assign var_a_val = var_a_ok ? 16'($signed(r_var_a)) : '0;
    assign var_b_val = var_b_ok ? 16'($signed(ram_q)) : '0;

    // Operand A reads the hit flag first and clears it for B
    assign hit_b = r_hit && (r_code_a != CODE_HIT);
    assign dec_a = decode(r_code_a, r_us, r_line, r_hit, var_a_val);
    assign dec_b = decode(r_code_b, r_us, r_line, hit_b, var_b_val);

    assign is_set = (r_action == ACT_SET);
    assign tgt_ok = is_var(r_code_a);

    // Arithmetic
    assign prod = r_opa * r_opb;
    assign sum  = 17'(r_opa) + 17'(r_opb);
    assign dif  = 17'(r_opa) - 17'(r_opb);
    assign o_sts.div_needed = is_set && (r_op == OP_DIV) && (r_opb != '0);

    always_comb begin
        case (r_op)
            OP_EQ:   cmp = (r_opa == r_opb);
            OP_LT:   cmp = (r_opa <  r_opb);
            OP_GT:   cmp = (r_opa >  r_opb);
            OP_NE:   cmp = (r_opa != r_opb);
            OP_GE:   cmp = (r_opa >= r_opb);
            OP_LE:   cmp = (r_opa <= r_opb);
            default: cmp = 1'b0;
        endcase
    end

    // Restoring divider step on magnitudes
    assign trial   = {r_rem, r_quo[15]} - {1'b0, r_dvs};
    assign div_val = r_qneg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    assign full = r_div_sel ? 33'(div_val) : r_res;
    always_comb begin
        if (full > 33'sd100) begin
            sat = SAT_MAX;
        end else if (full < -33'sd100) begin
            sat = SAT_MIN;
        end else begin
            sat = full[7:0];
        end
    end

    assign ram_we = i_cmd.commit && is_set && tgt_ok;

    svac_ram #(
        .WIDTH (8),
        .DEPTH (VARIABLE_COUNT),
        .AW    (IDX_W)
    ) u_var_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_a),
        .i_wdata (sat),
        .i_raddr (i_cmd.rd_b ? idx_b : idx_a),
        .o_rdata (ram_q)
    );

    // Payload and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= i_action;
            r_code_a <= i_first_operand;
            r_op     <= i_operator_code;
            r_code_b <= i_second_operand;
            r_us     <= i_ultrasonic_reading;
            r_line   <= i_line_reading;
            r_irv_nz <= (i_ir_event_value != '0);
        end
        if (i_cmd.cap_a) begin
            r_var_a <= ram_q;
        end
        if (i_cmd.load_ops) begin
            r_opa <= dec_a;
            r_opb <= dec_b;
        end
        if (i_cmd.calc) begin
            case (r_op)
                OP_MUL:  r_res <= 33'(prod);
                OP_ADD:  r_res <= 33'(sum);
                OP_SUB:  r_res <= 33'(dif);
                OP_EQ:   r_res <= 33'(r_opb);
                default: r_res <= '0;
            endcase
            r_truth   <= cmp;
            r_dz      <= is_set && (r_op == OP_DIV) && (r_opb == '0);
            r_div_sel <= o_sts.div_needed;
            r_rem     <= '0;
            r_quo     <= mag(r_opa);
            r_dvs     <= mag(r_opb);
            r_qneg    <= r_opa[15] ^ r_opb[15];
        end
        if (i_cmd.div_step) begin
            if (!trial[16]) begin
                r_rem <= trial[15:0];
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= {r_rem[14:0], r_quo[15]};
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
        if (i_cmd.commit) begin
            r_o_truth   <= ((r_action == ACT_IF) || (r_action == ACT_UNTIL)) ? r_truth :
                           (r_action == ACT_ELSE) ? !r_last_if : 1'b0;
            r_o_written <= (is_set && tgt_ok) ? sat : '0;
            r_o_dz      <= r_dz;
            r_o_bad     <= is_set && !tgt_ok;
        end
    end

    // Block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit     <= 1'b0;
            r_last_if <= 1'b1;
            r_vld     <= '0;
        end else if (i_cmd.commit) begin
            if (r_action == ACT_CLEAR) begin
                r_vld <= '0;
            end else if (ram_we) begin
                r_vld[idx_a] <= 1'b1;
            end
            if ((r_action == ACT_IR) && r_irv_nz) begin
                r_hit <= 1'b1;
            end else if ((is_set || (r_action == ACT_IF) || (r_action == ACT_UNTIL)) &&
                         ((r_code_a == CODE_HIT) || (r_code_b == CODE_HIT))) begin
                r_hit <= 1'b0;
            end
            if (r_action == ACT_IF) begin
                r_last_if <= r_truth;
            end
        end
    end

    assign o_truth          = r_o_truth;
    assign o_written_value  = r_o_written;
    assign o_divide_by_zero = r_o_dz;
    assign o_bad_target     = r_o_bad;

endmodule

[design/script_variable_alu_and_compare.sv]
// Top level: script variable ALU and compare unit.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one script action per item:
//   action, two operand codes, operator and the current sensor and IR values.
//   Output channel (o_valid / i_ready) returns exactly one result item per
//   input item: compare truth, the saturated value written, and the
//   divide-by-zero and bad-target flags.
// Timing:
//   One item is worked on at a time. After acceptance an item passes the
//   variable reads, operand decode, compute and commit steps to reach the
//   output register; a set with divide by a nonzero operand also runs the
//   16-step serial divider. Two variable reads go through the single read
//   port of the variable RAM.
// Reset (i_rst_n low, synchronous): all variables read as zero, the hit
//   flag clears, the last If truth is one, and both channels go idle.
// Stall: a finished result waits in the output register while i_ready is
//   low; the next item is still accepted and worked on, and holds at its
//   final step until the output register frees.
module script_variable_alu_and_compare import svac_pkg::*; #(
    parameter int VARIABLE_COUNT      = 10,
    parameter int FIRST_VARIABLE_CODE = 104
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_action,
    input  logic signed [7:0]  i_first_operand,
    input  logic [6:0]         i_operator_code,
    input  logic signed [7:0]  i_second_operand,
    input  logic signed [15:0] i_ultrasonic_reading,
    input  logic signed [15:0] i_line_reading,
    input  logic [15:0]        i_ir_event_value,
    // result item channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_truth,
    output logic signed [7:0]  o_written_value,
    output logic               o_divide_by_zero,
    output logic               o_bad_target
);

    t_cmd cmd;
    t_sts sts;

    // Sequence each item: read variables, decode, compute, commit
    svac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    // Hold the variable file, flags and the result register
    svac_dp #(
        .VARIABLE_COUNT      (VARIABLE_COUNT),
        .FIRST_VARIABLE_CODE (FIRST_VARIABLE_CODE)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_action             (i_action),
        .i_first_operand      (i_first_operand),
        .i_operator_code      (i_operator_code),
        .i_second_operand     (i_second_operand),
        .i_ultrasonic_reading (i_ultrasonic_reading),
        .i_line_reading       (i_line_reading),
        .i_ir_event_value     (i_ir_event_value),
        .o_truth              (o_truth),
        .o_written_value      (o_written_value),
        .o_divide_by_zero     (o_divide_by_zero),
        .o_bad_target         (o_bad_target)
    );

endmodule

[design/svac_checker.sv]
// Port-level checker for the script variable ALU, with its bind.
`include "assert_macros.svh"

module svac_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic [2:0]        i_action,
    input logic signed [7:0] i_first_operand,
    input logic [6:0]        i_operator_code,
    input logic signed [7:0] i_second_operand,
    input logic [15:0]       i_ultrasonic_reading,
    input logic [15:0]       i_line_reading,
    input logic [15:0]       i_ir_event_value,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_truth,
    input logic signed [7:0] o_written_value,
    input logic              o_divide_by_zero,
    input logic              o_bad_target
);

    `ASSERT_STD(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_written_value), "result item dropped or changed while stalled")
    `ASSERT_STD(a_sat_range, o_valid |-> (o_written_value <= 8'sd100) && (o_written_value >= -8'sd100), "written value outside saturation range")
    `ASSERT_STD(a_bad_no_write, o_valid && o_bad_target |-> (o_written_value == 8'sd0) && !o_truth, "bad target reported a written value")
    `ASSERT_STD(a_dz_zero, o_valid && o_divide_by_zero |-> (o_written_value == 8'sd0) && !o_truth, "divide by zero wrote a nonzero value")
    `ASSERT_STD(a_busy_after_accept, i_valid && o_ready |=> !o_ready, "second item accepted while one is at work")

endmodule

bind script_variable_alu_and_compare svac_checker u_svac_checker (.*);
